/* rtl/core/sihash_pkg.sv */
package sihash_pkg;

  localparam int N_BUCKETS     = 1024;
  localparam int ARENA_BYTES   = 1048576;
  localparam int MAX_KEY_BYTES = 256;

  localparam int IDX_W = $clog2(N_BUCKETS);
  localparam int OFF_W = 20;
  localparam int NF_W  = OFF_W + 1;
  localparam int LEN_W = $clog2(MAX_KEY_BYTES) + 1;
  localparam int KB_W  = $clog2(MAX_KEY_BYTES);
  localparam int J_W   = LEN_W + 1;

  localparam logic [NF_W-1:0] FIRST_FREE = NF_W'(42);

  // status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_TABLE_FULL = 2'd1;
  localparam logic [1:0] ST_ARENA_FULL = 2'd2;
  localparam logic [1:0] ST_TOO_LONG   = 2'd3;

  typedef struct packed {
    logic [7:0]  key_byte;
    logic        byte_valid;
    logic        key_last;
    logic [63:0] key_hash;
  } in_t;

  typedef struct packed {
    logic [19:0] key_offset;
    logic        was_new;
    logic [1:0]  status;
  } out_t;

  typedef struct packed {
    logic [OFF_W-1:0] offset;
    logic [63:0]      hash;
  } bkt_t;

  typedef enum logic [2:0] {
    RES_NEW,
    RES_FOUND,
    RES_TABLE,
    RES_ARENA,
    RES_LONG
  } res_code_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_COLLECT,
    S_PROBE_RD,
    S_PROBE_CHK,
    S_CMP_RD,
    S_CMP_CHK,
    S_WR_RD,
    S_WR_BYTE,
    S_WR_BKT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic      clr_wr;
    logic      collect;
    logic      start;
    logic      bkt_rd;
    logic      probe_next;
    logic      j_clr;
    logic      j_inc;
    logic      byte_rd;
    logic      arena_wr;
    logic      bkt_wr;
    logic      set_code;
    res_code_t code;
    logic      res_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic key_last;
    logic ovf_at_last;
    logic bkt_empty;
    logic hash_eq;
    logic arena_fits;
    logic probe_last;
    logic byte_eq;
    logic byte_last;
    logic out_free;
  } sts_t;

endpackage

/* rtl/core/string_interning_hash_table_unit.sv */
// Channel | Dir | Handshake            | Beat
// key     | in  | key_valid/key_stall  | one key byte, end flag, hash
// res     | out | res_valid/res_stall  | arena offset, new flag, status
//
// Reset clears the bucket table in a pass over all 1024 buckets; no beat is taken meanwhile.
// Key bytes are taken one per cycle while key_stall is low; the lookup begins on the end beat.
// Each probe of the single-port bucket RAM is a read state then a check state; each byte
// compared or written through the arena port is a read, then a check or a write; an insert
// ends with a bucket write, and the result is then handed over.
// The next key streams in while a result waits on res_stall.
module string_interning_hash_table_unit (
  input  logic             clk,
  input  logic             rst,
  input  logic             key_valid,
  output logic             key_stall,
  input  sihash_pkg::in_t  key_beat,
  output logic             res_valid,
  input  logic             res_stall,
  output sihash_pkg::out_t res_data
);
  import sihash_pkg::*;

  cmd_t cmd;
  sts_t sts;

  sihash_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .key_valid (key_valid),
    .key_stall (key_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  sihash_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .key_beat  (key_beat),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data),
    .cmd       (cmd),
    .sts       (sts)
  );

  // a good result always points past the reserved head of the arena
  a_ok_offset: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.status == ST_OK |-> res_data.key_offset != '0)
    else $error("ok result with zero offset");

  // error results carry no offset
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.status != ST_OK |-> res_data.key_offset == '0 && !res_data.was_new)
    else $error("error result with offset or new flag");

  // no key beat is taken at the start of the clearing pass that follows reset
  a_clear_stall: assert property (@(posedge clk)
    $past(rst) |-> key_stall)
    else $error("key beat open during clearing pass");

endmodule

/* rtl/core/sihash_ctrl.sv */
module sihash_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              key_valid,
  output logic              key_stall,
  input  sihash_pkg::sts_t  sts,
  output sihash_pkg::cmd_t  cmd
);
  import sihash_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:     if (sts.clr_last) state_next = S_COLLECT;
      S_COLLECT: begin
        if (key_valid && sts.key_last) begin
          state_next = sts.ovf_at_last ? S_DONE : S_PROBE_RD;
        end
      end
      S_PROBE_RD:  state_next = S_PROBE_CHK;
      S_PROBE_CHK: begin
        if (sts.bkt_empty) begin
          state_next = sts.arena_fits ? S_WR_RD : S_DONE;
        end else if (sts.hash_eq) begin
          state_next = S_CMP_RD;
        end else begin
          state_next = sts.probe_last ? S_DONE : S_PROBE_RD;
        end
      end
      S_CMP_RD:    state_next = S_CMP_CHK;
      S_CMP_CHK: begin
        if (!sts.byte_eq) begin
          state_next = sts.probe_last ? S_DONE : S_PROBE_RD;
        end else if (sts.byte_last) begin
          state_next = S_DONE;
        end else begin
          state_next = S_CMP_RD;
        end
      end
      S_WR_RD:     state_next = S_WR_BYTE;
      S_WR_BYTE:   state_next = sts.byte_last ? S_WR_BKT : S_WR_RD;
      S_WR_BKT:    state_next = S_DONE;
      S_DONE:      if (sts.out_free) state_next = S_COLLECT;
      default:     state_next = S_CLEAR;
    endcase
  end

  // commands
  always_comb begin
    cmd = '0;
    cmd.code = RES_NEW;
    key_stall = (state != S_COLLECT);
    unique case (state)
      S_CLEAR:     cmd.clr_wr = 1'b1;
      S_COLLECT: begin
        cmd.collect = key_valid;
        if (key_valid && sts.key_last) begin
          if (sts.ovf_at_last) begin
            cmd.set_code = 1'b1;
            cmd.code     = RES_LONG;
          end else begin
            cmd.start = 1'b1;
          end
        end
      end
      S_PROBE_RD:  cmd.bkt_rd = 1'b1;
      S_PROBE_CHK: begin
        cmd.j_clr = 1'b1;
        if (sts.bkt_empty) begin
          if (!sts.arena_fits) begin
            cmd.set_code = 1'b1;
            cmd.code     = RES_ARENA;
          end
        end else if (!sts.hash_eq) begin
          if (sts.probe_last) begin
            cmd.set_code = 1'b1;
            cmd.code     = RES_TABLE;
          end else begin
            cmd.probe_next = 1'b1;
          end
        end
      end
      S_CMP_RD:    cmd.byte_rd = 1'b1;
      S_CMP_CHK: begin
        if (!sts.byte_eq) begin
          if (sts.probe_last) begin
            cmd.set_code = 1'b1;
            cmd.code     = RES_TABLE;
          end else begin
            cmd.probe_next = 1'b1;
          end
        end else if (sts.byte_last) begin
          cmd.set_code = 1'b1;
          cmd.code     = RES_FOUND;
        end else begin
          cmd.j_inc = 1'b1;
        end
      end
      S_WR_RD:     cmd.byte_rd = 1'b1;
      S_WR_BYTE: begin
        cmd.arena_wr = 1'b1;
        cmd.j_inc    = !sts.byte_last;
      end
      S_WR_BKT: begin
        cmd.bkt_wr   = 1'b1;
        cmd.set_code = 1'b1;
        cmd.code     = RES_NEW;
      end
      S_DONE:      cmd.res_load = sts.out_free;
      default:     cmd = '0;
    endcase
  end

endmodule

/* rtl/core/sihash_dpath.sv */
module sihash_dpath (
  input  logic              clk,
  input  logic              rst,
  input  sihash_pkg::in_t   key_beat,
  output logic              res_valid,
  input  logic              res_stall,
  output sihash_pkg::out_t  res_data,
  input  sihash_pkg::cmd_t  cmd,
  output sihash_pkg::sts_t  sts
);
  import sihash_pkg::*;

  bkt_t              bkt_mem [N_BUCKETS];
  logic [7:0]        arena_mem [ARENA_BYTES];
  logic [7:0]        kbuf_mem [MAX_KEY_BYTES];

  logic [IDX_W-1:0]  clr_idx;
  logic [IDX_W-1:0]  idx;
  logic [IDX_W-1:0]  probe_cnt;
  logic [63:0]       hash;
  logic [LEN_W-1:0]  len;
  logic              ovf;
  logic [NF_W-1:0]   next_free;
  logic [J_W-1:0]    j;
  bkt_t              bkt_q;
  logic [7:0]        arena_q;
  logic [7:0]        kbuf_q;
  logic [OFF_W-1:0]  res_off;
  logic              res_new;
  logic [1:0]        res_st;

  logic [7:0]        exp_byte;
  logic [OFF_W-1:0]  byte_addr;
  logic [KB_W-1:0]   kbuf_raddr;
  logic [NF_W:0]     need_end;
  logic              len_full;

  assign len_full   = (len == LEN_W'(MAX_KEY_BYTES));
  assign byte_addr  = OFF_W'(bkt_q.offset + OFF_W'(j));
  assign kbuf_raddr = KB_W'(j - J_W'(2));
  assign need_end   = (NF_W+1)'(next_free) + (NF_W+1)'(len) + (NF_W+1)'(2);

  // byte j of a stored entry: little-endian length word, then the key
  always_comb begin
    if (j == J_W'(0)) begin
      exp_byte = len[7:0];
    end else if (j == J_W'(1)) begin
      exp_byte = 8'(len >> 8);
    end else begin
      exp_byte = kbuf_q;
    end
  end

  // status to controller
  always_comb begin
    sts.clr_last    = (clr_idx == IDX_W'(N_BUCKETS - 1));
    sts.key_last    = key_beat.key_last;
    sts.ovf_at_last = ovf || (key_beat.byte_valid && len_full);
    sts.bkt_empty   = (bkt_q.offset == '0);
    sts.hash_eq     = (bkt_q.hash == hash);
    sts.arena_fits  = (need_end <= (NF_W+1)'(ARENA_BYTES));
    sts.probe_last  = (probe_cnt == IDX_W'(N_BUCKETS - 1));
    sts.byte_eq     = (arena_q == exp_byte);
    sts.byte_last   = (j == J_W'(len) + J_W'(1));
    sts.out_free    = !res_valid || !res_stall;
  end

  // bucket table: clearing pass after reset, then probe reads and inserts
  always_ff @(posedge clk) begin
    if (cmd.clr_wr) begin
      bkt_mem[clr_idx] <= '0;
    end else if (cmd.bkt_wr) begin
      bkt_mem[idx] <= '{offset: next_free[OFF_W-1:0], hash: hash};
    end
    if (cmd.bkt_rd) begin
      bkt_q <= bkt_mem[idx];
    end
  end

  // byte arena and key buffer
  always_ff @(posedge clk) begin
    if (cmd.arena_wr) begin
      arena_mem[OFF_W'(next_free[OFF_W-1:0] + OFF_W'(j))] <= exp_byte;
    end
    if (cmd.byte_rd) begin
      arena_q <= arena_mem[byte_addr];
      kbuf_q  <= kbuf_mem[kbuf_raddr];
    end
    if (cmd.collect && key_beat.byte_valid && !len_full) begin
      kbuf_mem[len[KB_W-1:0]] <= key_beat.key_byte;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx   <= '0;
      len       <= '0;
      ovf       <= 1'b0;
      next_free <= FIRST_FREE;
      res_valid <= 1'b0;
    end else begin
      if (cmd.clr_wr) clr_idx <= clr_idx + IDX_W'(1);
      if (cmd.res_load) begin
        len <= '0;
        ovf <= 1'b0;
      end else if (cmd.collect && key_beat.byte_valid) begin
        if (len_full) ovf <= 1'b1;
        else          len <= len + LEN_W'(1);
      end
      if (cmd.bkt_wr) next_free <= NF_W'(need_end);
      if (cmd.res_load)          res_valid <= 1'b1;
      else if (!res_stall)       res_valid <= 1'b0;
    end
  end

  // probe position, byte counter and result
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      hash      <= key_beat.key_hash;
      idx       <= key_beat.key_hash[IDX_W-1:0];
      probe_cnt <= '0;
    end else if (cmd.probe_next) begin
      idx       <= idx + IDX_W'(1);
      probe_cnt <= probe_cnt + IDX_W'(1);
    end
    if (cmd.j_clr)      j <= '0;
    else if (cmd.j_inc) j <= j + J_W'(1);
    if (cmd.set_code) begin
      case (cmd.code)
        RES_NEW: begin
          res_off <= next_free[OFF_W-1:0];
          res_new <= 1'b1;
          res_st  <= ST_OK;
        end
        RES_FOUND: begin
          res_off <= bkt_q.offset;
          res_new <= 1'b0;
          res_st  <= ST_OK;
        end
        RES_TABLE: begin
          res_off <= '0;
          res_new <= 1'b0;
          res_st  <= ST_TABLE_FULL;
        end
        RES_ARENA: begin
          res_off <= '0;
          res_new <= 1'b0;
          res_st  <= ST_ARENA_FULL;
        end
        default: begin
          res_off <= '0;
          res_new <= 1'b0;
          res_st  <= ST_TOO_LONG;
        end
      endcase
    end
    if (cmd.res_load) begin
      res_data <= '{key_offset: res_off, was_new: res_new, status: res_st};
    end
  end

endmodule
